// ----- rtl/core/dlpd_pkg.sv -----
`default_nettype none
package dlpd_pkg;

  localparam int STORE_DEPTH = 512;
  localparam int IDX_W       = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
  localparam int MAG_W       = 33;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [MAG_W-1:0] POS_LIMIT = 33'h0_7FFF_FFFF;
  localparam logic [MAG_W-1:0] NEG_LIMIT = 33'h0_8000_0000;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_BADCHAR  = 3'd1;
  localparam logic [2:0] ST_SIGNONLY = 3'd2;
  localparam logic [2:0] ST_RANGE    = 3'd3;
  localparam logic [2:0] ST_DUP      = 3'd4;
  localparam logic [2:0] ST_FULL     = 3'd5;
  localparam logic [2:0] ST_ABORTED  = 3'd6;

  typedef struct packed {
    logic take;
    logic close;
    logic search;
    logic finish;
  } dlpd_cmd_t;

  typedef struct packed {
    logic closes;
    logic do_search;
    logic hit;
    logic last;
    logic out_free;
  } dlpd_sts_t;

endpackage
`default_nettype wire

// ----- rtl/core/dlpd_ctrl.sv -----
`default_nettype none
module dlpd_ctrl
  import dlpd_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  input  wire dlpd_sts_t sts_i,
  output dlpd_cmd_t      cmd_o
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_CLOSE  = 2'd1;
  localparam logic [1:0] S_SEARCH = 2'd2;
  localparam logic [1:0] S_FINISH = 2'd3;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        cmd_o.take = in_valid_i;
        if (in_valid_i && sts_i.closes) begin
          state_d = S_CLOSE;
        end
      end
      S_CLOSE: begin
        cmd_o.close = 1'b1;
        state_d = sts_i.do_search ? S_SEARCH : S_FINISH;
      end
      S_SEARCH: begin
        cmd_o.search = 1'b1;
        if (sts_i.hit || sts_i.last) begin
          state_d = S_FINISH;
        end
      end
      S_FINISH: begin
        cmd_o.finish = sts_i.out_free;
        if (sts_i.out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign in_stall_o = (state_q != S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/dlpd_dp.sv -----
`default_nettype none
module dlpd_dp
  import dlpd_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic [7:0]  char_code_i,
  input  wire logic        end_of_arg_i,
  input  wire dlpd_cmd_t   cmd_i,
  output dlpd_sts_t        sts_o,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic signed [31:0] value_o,
  output logic [2:0]       status_o,
  output logic [8:0]       slot_o
);

  logic [31:0]      store_mem [STORE_DEPTH];
  logic [31:0]      rd_q;
  logic [IDX_W-1:0] rd_addr;

  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] srch_q, srch_d;
  logic [MAG_W-1:0] mag_q, mag_d;
  logic             neg_q, neg_d;
  logic             in_tok_q, in_tok_d;
  logic             saw_q, saw_d;
  logic             bad_q, bad_d;
  logic             abort_q, abort_d;
  logic             out_valid_q, out_valid_d;

  logic [31:0]      res_val_q, res_val_d;
  logic [2:0]       res_st_q, res_st_d;
  logic [31:0]      val_q;
  logic [2:0]       st_q;
  logic [8:0]       slot_q;

  logic             is_space, is_sign, is_digit, first;
  logic [MAG_W+3:0] mag_x10;
  logic [2:0]       close_st;
  logic [31:0]      close_val;
  logic             full;
  logic [2:0]       fin_st;

  assign is_space = (char_code_i == CH_SPACE);
  assign is_sign  = (char_code_i == CH_PLUS) || (char_code_i == CH_MINUS);
  assign is_digit = (char_code_i >= CH_ZERO) && (char_code_i <= CH_NINE);
  assign first    = !in_tok_q;
  assign mag_x10  = ({4'b0, mag_q} << 3) + ({4'b0, mag_q} << 1)
                  + (MAG_W+4)'(char_code_i[3:0]);

  always_comb begin
    close_val = '0;
    priority if (abort_q) begin
      close_st = ST_ABORTED;
    end else if (bad_q) begin
      close_st = ST_BADCHAR;
    end else if (!saw_q) begin
      close_st = ST_SIGNONLY;
    end else if (mag_q > (neg_q ? NEG_LIMIT : POS_LIMIT)) begin
      close_st = ST_RANGE;
    end else begin
      close_st  = ST_OK;
      close_val = neg_q ? (32'd0 - mag_q[31:0]) : mag_q[31:0];
    end
  end

  assign full   = (count_q == CNT_W'(STORE_DEPTH));
  assign fin_st = ((res_st_q == ST_OK) && full) ? ST_FULL : res_st_q;

  assign sts_o.closes    = (is_space || end_of_arg_i) && (in_tok_q || !is_space);
  assign sts_o.do_search = (close_st == ST_OK) && (count_q != '0);
  assign sts_o.hit       = (rd_q == res_val_q);
  assign sts_o.last      = (srch_q == count_q);
  assign sts_o.out_free  = !out_valid_q || !out_stall_i;

  assign rd_addr = cmd_i.close ? '0 : srch_q[IDX_W-1:0];

  always_comb begin
    count_d     = count_q;
    srch_d      = srch_q;
    mag_d       = mag_q;
    neg_d       = neg_q;
    in_tok_d    = in_tok_q;
    saw_d       = saw_q;
    bad_d       = bad_q;
    abort_d     = abort_q;
    res_val_d   = res_val_q;
    res_st_d    = res_st_q;
    out_valid_d = out_valid_q && out_stall_i;
    if (cmd_i.take && !is_space) begin
      in_tok_d = 1'b1;
      priority if (first && is_sign) begin
        neg_d = (char_code_i == CH_MINUS);
      end else if (is_digit) begin
        mag_d = (mag_x10[MAG_W+3:MAG_W] != '0) ? '1 : mag_x10[MAG_W-1:0];
        saw_d = 1'b1;
      end else begin
        bad_d = 1'b1;
      end
    end
    if (cmd_i.close) begin
      res_val_d = close_val;
      res_st_d  = close_st;
      srch_d    = CNT_W'(1);
      mag_d     = '0;
      neg_d     = 1'b0;
      in_tok_d  = 1'b0;
      saw_d     = 1'b0;
      bad_d     = 1'b0;
    end
    if (cmd_i.search) begin
      priority if (sts_o.hit) begin
        res_st_d = ST_DUP;
      end else if (!sts_o.last) begin
        srch_d = srch_q + CNT_W'(1);
      end
    end
    if (cmd_i.finish) begin
      out_valid_d = 1'b1;
      if (fin_st == ST_OK) begin
        count_d = count_q + CNT_W'(1);
      end else if (fin_st != ST_ABORTED) begin
        abort_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      srch_q      <= '0;
      mag_q       <= '0;
      neg_q       <= 1'b0;
      in_tok_q    <= 1'b0;
      saw_q       <= 1'b0;
      bad_q       <= 1'b0;
      abort_q     <= 1'b0;
      res_st_q    <= ST_OK;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      srch_q      <= srch_d;
      mag_q       <= mag_d;
      neg_q       <= neg_d;
      in_tok_q    <= in_tok_d;
      saw_q       <= saw_d;
      bad_q       <= bad_d;
      abort_q     <= abort_d;
      res_st_q    <= res_st_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_val_q <= res_val_d;
    rd_q      <= store_mem[rd_addr];
    if (cmd_i.finish && (fin_st == ST_OK)) begin
      store_mem[count_q[IDX_W-1:0]] <= res_val_q;
    end
    if (cmd_i.finish) begin
      val_q  <= res_val_q;
      st_q   <= fin_st;
      slot_q <= (fin_st == ST_OK) ? 9'(count_q) : 9'd0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign value_o     = val_q;
  assign status_o    = st_q;
  assign slot_o      = slot_q;

endmodule
`default_nettype wire

// ----- rtl/core/decimal_list_parse_dedup_unit.sv -----
// Decimal list parser with duplicate check.
// Input channel: one text byte per item (char_code_i) with end_of_arg_i marking
// the last byte of an argument. A space or the last byte closes the open token.
// Output channel: one item per closed token: value_o, status_o and slot_o.
// Both channels accept at a clock edge with valid high and stall low.
// Sequencing: a byte that does not close a token is taken without a stall. A
// closing byte holds the input through the close step, the duplicate search
// (one stored value scanned per cycle, set by the single read port of the value
// store) and the finish step. The result becomes valid in the cycle where the
// input frees again.
// A finished result waits in the output register while the receiver stalls;
// the block holds in its last step until that register frees, then takes input
// again. Stray bytes keep flowing while a result waits.
// Reset clears the token state, the store count and the error latch; stored
// values need no clearing since only written entries are searched.
// After the first error every later token reports aborted.
`default_nettype none
module decimal_list_parse_dedup_unit
  import dlpd_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [7:0]         char_code_i,
  input  wire logic               end_of_arg_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic signed [31:0]      value_o,
  output logic [2:0]              status_o,
  output logic [8:0]              slot_o
);

  dlpd_cmd_t cmd;
  dlpd_sts_t sts;

  dlpd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  dlpd_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .char_code_i  (char_code_i),
    .end_of_arg_i (end_of_arg_i),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .value_o      (value_o),
    .status_o     (status_o),
    .slot_o       (slot_o)
  );

endmodule
`default_nettype wire

// ----- rtl/core/dlpd_chk.sv -----
`default_nettype none
module dlpd_chk
  import dlpd_pkg::*;
(
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_stall_o,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic [31:0] value_o,
  input wire logic [2:0]  status_o,
  input wire logic [8:0]  slot_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(value_o) && $stable(status_o)
      && $stable(slot_o))
    else $error("result changed while stalled");

  a_rise_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared without a closing step");

  a_zero_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_BADCHAR || status_o == ST_SIGNONLY
      || status_o == ST_RANGE || status_o == ST_ABORTED) |-> value_o == '0)
    else $error("error result carries a value");

  a_zero_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_OK |-> slot_o == '0)
    else $error("failed result carries a slot");

endmodule

bind decimal_list_parse_dedup_unit dlpd_chk u_dlpd_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .value_o     (value_o),
  .status_o    (status_o),
  .slot_o      (slot_o)
);
`default_nettype wire

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps
module tb_top;
  import dlpd_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 2_000_000;
  localparam logic [MAG_W-1:0] MAG_MAX = '1;

  typedef struct packed {
    logic [7:0] code;
    logic       eoa;
    logic       drain;
  } text_byte_t;

  typedef struct packed {
    logic [31:0] value;
    logic [2:0]  status;
    logic [8:0]  slot;
  } parse_res_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [7:0]         char_code = 8'h00;
  logic               end_of_arg = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [31:0] value;
  logic [2:0]         status;
  logic [8:0]         slot;

  decimal_list_parse_dedup_unit u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .char_code_i  (char_code),
    .end_of_arg_i (end_of_arg),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .value_o      (value),
    .status_o     (status),
    .slot_o       (slot)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  text_byte_t  text_bytes[$];
  parse_res_t  expected_parses[$];
  bit          val_used[logic [31:0]];
  logic [31:0] used_vals[$];

  logic [MAG_W-1:0] tok_mag;
  logic             tok_neg, tok_open, tok_digit, tok_bad, latched;
  logic [2:0]       first_err;
  int               stored_n;
  logic [31:0]      stored_vals[STORE_DEPTH];

  int          mismatches = 0;
  int          bytes_taken = 0;
  int          results_seen = 0;
  int          status_seen[8];
  int unsigned cycle_cnt = 0;
  int          gap_left = 0;
  int          hold_left = 0;
  bit          drv_idle = 1'b1;
  bit          rcv_idle = 1'b1;

  task automatic parse_byte(input logic [7:0] c, input logic eoa);
    logic [63:0]      m;
    logic [31:0]      v;
    logic [2:0]       st;
    logic [8:0]       pos;
    logic [MAG_W-1:0] lim;
    int               i;
    if (c != CH_SPACE) begin
      if (!tok_open && (c == CH_PLUS || c == CH_MINUS)) begin
        tok_neg = (c == CH_MINUS);
      end else if (c >= CH_ZERO && c <= CH_NINE) begin
        m = 64'(tok_mag) * 64'd10 + 64'(c - CH_ZERO);
        tok_mag = (m > 64'(MAG_MAX)) ? MAG_MAX : m[MAG_W-1:0];
        tok_digit = 1'b1;
      end else begin
        tok_bad = 1'b1;
      end
      tok_open = 1'b1;
    end
    if ((c == CH_SPACE || eoa) && tok_open) begin
      v = '0;
      pos = '0;
      lim = tok_neg ? NEG_LIMIT : POS_LIMIT;
      if (latched) st = ST_ABORTED;
      else if (tok_bad) st = ST_BADCHAR;
      else if (!tok_digit) st = ST_SIGNONLY;
      else if (tok_mag > lim) st = ST_RANGE;
      else begin
        v = tok_neg ? 32'd0 - tok_mag[31:0] : tok_mag[31:0];
        st = ST_OK;
        for (i = 0; i < stored_n; i++) begin
          if (stored_vals[i] == v) st = ST_DUP;
        end
        if (st == ST_OK) begin
          if (stored_n >= STORE_DEPTH) begin
            st = ST_FULL;
          end else begin
            pos = stored_n[8:0];
            stored_vals[stored_n] = v;
            stored_n++;
          end
        end
      end
      if (st != ST_OK && st != ST_ABORTED) begin
        latched = 1'b1;
        first_err = st;
      end
      expected_parses.push_back('{value: v, status: st, slot: pos});
      tok_mag = '0;
      tok_neg = 1'b0;
      tok_open = 1'b0;
      tok_digit = 1'b0;
      tok_bad = 1'b0;
    end
  endtask

  task automatic put_byte(input logic [7:0] c, input logic eoa, input logic drain);
    text_bytes.push_back('{code: c, eoa: eoa, drain: drain});
  endtask

  task automatic put_text(input string s, input logic eoa_last);
    int i;
    for (i = 0; i < s.len(); i++) put_byte(s[i], eoa_last && (i == s.len() - 1), 1'b0);
  endtask

  task automatic put_token(input string s, input logic drain);
    int how;
    if (drain) put_byte(CH_SPACE, 1'b0, 1'b1);
    if ($urandom_range(0, 5) == 0) put_byte(CH_SPACE, 1'b0, 1'b0);
    how = $urandom_range(0, 4);
    put_text(s, how < 2);
    case (how)
      2: put_byte(CH_SPACE, 1'b0, 1'b0);
      3: put_byte(CH_SPACE, 1'b1, 1'b0);
      4: repeat (2) put_byte(CH_SPACE, 1'($urandom_range(0, 1)), 1'b0);
      default: ;
    endcase
  endtask

  function automatic string ok_text(input logic [31:0] v);
    longint a;
    string  s, sg;
    int     n;
    a = signed'(v);
    if (a < 0) begin
      sg = "-";
      a = -a;
    end else if ($urandom_range(0, 3) == 0) begin
      sg = "+";
    end else if (a == 0 && $urandom_range(0, 1) == 1) begin
      sg = "-";
    end else begin
      sg = "";
    end
    s = $sformatf("%0d", a);
    n = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 3) : 0;
    repeat (n) s = {"0", s};
    return {sg, s};
  endfunction

  function automatic logic [31:0] fresh_value();
    logic [31:0] v;
    do begin
      case ($urandom_range(0, 7))
        0: v = $urandom;
        1: v = $urandom_range(0, 99999);
        default: v = $urandom_range(0, 999);
      endcase
      if ($urandom_range(0, 1) == 1) v = 32'd0 - v;
    end while (val_used.exists(v));
    return v;
  endfunction

  task automatic keep_value(input logic [31:0] v);
    val_used[v] = 1'b1;
    used_vals.push_back(v);
  endtask

  initial begin : stimulus
    logic [2:0]  err_kinds[5];
    logic [31:0] v;
    logic [7:0]  b;
    string       s;
    err_kinds = '{ST_BADCHAR, ST_SIGNONLY, ST_RANGE, ST_DUP, ST_FULL};

    put_byte(CH_SPACE, 1'b1, 1'b0);
    put_text("-2147483648", 1'b1);
    keep_value(32'h8000_0000);
    put_text("+2147483647 ", 1'b0);
    keep_value(32'h7FFF_FFFF);
    put_text("0", 1'b1);
    keep_value(32'h0);

    while (used_vals.size() < 80) begin
      v = fresh_value();
      keep_value(v);
      put_token(ok_text(v), (used_vals.size() % 32) == 0);
      if ($urandom_range(0, 9) == 0) put_byte(CH_SPACE, 1'($urandom_range(0, 1)), 1'b0);
    end

    put_byte(CH_SPACE, 1'b0, 1'b1);
    case (err_kinds[$urandom_range(0, 4)])
      ST_BADCHAR: begin
        if ($urandom_range(0, 3) == 0) b = 8'h00;
        else begin
          do b = 8'($urandom_range(0, 255));
          while (b == CH_SPACE || (b >= CH_ZERO && b <= CH_NINE));
        end
        s = ($urandom_range(0, 1) == 1) ? "-" : "";
        repeat ($urandom_range(0, 2)) s = $sformatf("%s%0d", s, $urandom_range(0, 9));
        if (s.len() == 0 && (b == CH_PLUS || b == CH_MINUS)) s = "7";
        put_text(s, 1'b0);
        put_byte(b, 1'b0, 1'b0);
        s = "";
        repeat ($urandom_range(0, 2)) s = $sformatf("%s%0d", s, $urandom_range(0, 9));
        put_text(s, 1'b0);
        put_byte(CH_SPACE, 1'($urandom_range(0, 1)), 1'b0);
      end
      ST_SIGNONLY: put_token(($urandom_range(0, 1) == 1) ? "+" : "-", 1'b0);
      ST_RANGE: begin
        case ($urandom_range(0, 2))
          0: s = "2147483648";
          1: s = "-2147483649";
          default: begin
            s = ($urandom_range(0, 1) == 1) ? "-1" : "1";
            repeat ($urandom_range(10, 25)) s = $sformatf("%s%0d", s, $urandom_range(0, 9));
          end
        endcase
        put_token(s, 1'b0);
      end
      ST_DUP: put_token(ok_text(used_vals[$urandom_range(0, used_vals.size() - 1)]), 1'b0);
      default: put_token(ok_text(fresh_value()), 1'b0);
    endcase

    repeat (20) begin
      if ($urandom_range(0, 1) == 1) put_token(ok_text(fresh_value()), 1'b0);
      else repeat (4) put_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0, 1'b0);
    end
    put_byte(CH_SPACE, 1'b1, 1'b0);
  end

  always @(posedge clk_i or negedge rst_ni) begin : feed
    text_byte_t nxt;
    logic       send;
    if (!rst_ni) begin
      in_valid <= 1'b0;
      char_code <= 8'h00;
      end_of_arg <= 1'b0;
      gap_left = 0;
      tok_mag = '0;
      tok_neg = 1'b0;
      tok_open = 1'b0;
      tok_digit = 1'b0;
      tok_bad = 1'b0;
      latched = 1'b0;
      first_err = ST_OK;
      stored_n = 0;
    end else begin
      send = in_valid;
      if (in_valid && !in_stall) begin
        parse_byte(char_code, end_of_arg);
        bytes_taken++;
        send = 1'b0;
      end
      if (!send) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (text_bytes.size() > 0 &&
                     !(text_bytes[0].drain && expected_parses.size() > 0)) begin
          nxt = text_bytes.pop_front();
          char_code <= nxt.code;
          end_of_arg <= nxt.eoa;
          send = 1'b1;
          if ($urandom_range(0, 63) == 0) drv_idle = !drv_idle;
          gap_left = drv_idle ? $urandom_range(0, 7) : 0;
        end
      end
      in_valid <= send;
    end
  end

  task automatic note_mismatch(input string what, input logic [31:0] exp_v,
                               input logic [31:0] got_v);
    mismatches++;
    if (mismatches <= 50) begin
      $display("%0t %s mismatch: expected %h, got %h", $time, what, exp_v, got_v);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : sink
    parse_res_t want;
    if (!rst_ni) begin
      out_stall <= 1'b0;
      hold_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        status_seen[status]++;
        if (expected_parses.size() == 0) begin
          mismatches++;
          $display("%0t unexpected item: expected none, got value %h status %0d slot %0d",
                   $time, value, status, slot);
        end else begin
          want = expected_parses.pop_front();
          if (value !== want.value) note_mismatch("value", want.value, value);
          if (status !== want.status) note_mismatch("status", 32'(want.status), 32'(status));
          if (slot !== want.slot) note_mismatch("slot", 32'(want.slot), 32'(slot));
        end
        if (results_seen == 40) begin
          hold_left = 600;
        end else begin
          if ($urandom_range(0, 63) == 0) rcv_idle = !rcv_idle;
          hold_left = rcv_idle ? $urandom_range(0, 7) : 0;
        end
      end else if (hold_left > 0) begin
        hold_left--;
      end
      out_stall <= (hold_left > 0);
    end
  end

  always @(posedge clk_i) cycle_cnt <= cycle_cnt + 1;

  initial begin : watchdog
    while (cycle_cnt < CYCLE_LIMIT) @(posedge clk_i);
    $display("%0t timeout: %0d items still pending", $time, expected_parses.size());
    $display("[decimal_list_parse_dedup_unit] ERROR");
    $finish;
  end

  initial begin : run_ctrl
    rst_ni = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    while (text_bytes.size() > 0 || in_valid) @(posedge clk_i);
    while (expected_parses.size() > 0) @(posedge clk_i);
    repeat (STORE_DEPTH + 32) @(posedge clk_i);
    $display("covered %0d text bytes, %0d tokens: %0d stored, %0d aborted, latched error %0d",
             bytes_taken, results_seen, status_seen[ST_OK], status_seen[ST_ABORTED], first_err);
    $display("store filled to %0d of %0d entries, %0d mismatches", stored_n, STORE_DEPTH,
             mismatches);
    if (mismatches == 0) begin
      $display("[decimal_list_parse_dedup_unit] OK");
    end else begin
      $display("[decimal_list_parse_dedup_unit] ERROR");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/dlpd_pkg.sv
rtl/core/dlpd_ctrl.sv
rtl/core/dlpd_dp.sv
rtl/core/decimal_list_parse_dedup_unit.sv
rtl/core/dlpd_chk.sv
sim/tb_top.sv
